// ===== hdl/spobs_pkg.sv =====
// shared types, constants and pair-cost functions for the stem pairing best-select block
package spobs_pkg;

	// base codes and stem geometry
	localparam int CODE_W       = 3;
	localparam int STEM_ONE_N   = 7;
	localparam int STEM_TWO_N   = 3;
	localparam int STEM_THREE_N = 5;
	localparam int STEM_FOUR_N  = 5;
	localparam int STEM_ONE_W   = 2 * STEM_ONE_N * CODE_W;
	localparam int STEM_TWO_W   = 2 * STEM_TWO_N * CODE_W;
	localparam int STEM_THREE_W = 2 * STEM_THREE_N * CODE_W;
	localparam int STEM_FOUR_W  = 2 * STEM_FOUR_N * CODE_W;
	localparam int INTRON_W     = 8;
	localparam int SCORE_W      = 7;
	localparam int COST_W       = 3;

	typedef logic [CODE_W-1:0]     base_t;
	typedef logic [COST_W-1:0]     cost_t;
	typedef logic [SCORE_W-1:0]    score_t;
	typedef logic [INTRON_W-1:0]   intron_t;
	typedef logic [STEM_ONE_W-1:0] stem_word_t;

	localparam base_t BASE_A = 3'd0;
	localparam base_t BASE_C = 3'd1;
	localparam base_t BASE_G = 3'd2;
	localparam base_t BASE_T = 3'd3;

	localparam cost_t COST_PAIR     = 3'd0;
	localparam cost_t COST_WOBBLE   = 3'd1;
	localparam cost_t COST_MISMATCH = 3'd5;

	localparam intron_t INTRON_LIMIT   = 8'd7;
	localparam score_t  INTRON_PENALTY = 7'd2;

	// control of the cluster stage
	typedef struct packed {
		logic valid;
		logic flush;
	} sel_ctrl_t;

	// cost of one base pair; any code above t fails every match
	function automatic cost_t pair_cost(base_t x, base_t y);
		cost_t c;
		if ((x == BASE_A && y == BASE_T) || (x == BASE_T && y == BASE_A) ||
			(x == BASE_C && y == BASE_G) || (x == BASE_G && y == BASE_C)) begin
			c = COST_PAIR;
		end else if ((x == BASE_G && y == BASE_T) || (x == BASE_T && y == BASE_G)) begin
			c = COST_WOBBLE;
		end else begin
			c = COST_MISMATCH;
		end
		return c;
	endfunction

	// cost of one stem of n pairs; five-prime base i pairs with three-prime base n-1-i
	function automatic score_t stem_cost(stem_word_t v, int n);
		score_t sum;
		sum = '0;
		for (int i = 0; i < STEM_ONE_N; i++) begin
			if (i < n) begin
				sum = sum + score_t'(pair_cost(v[CODE_W*i +: CODE_W],
					v[CODE_W*(2*n-1-i) +: CODE_W]));
			end
		end
		return sum;
	endfunction

endpackage

// ===== hdl/spobs_cand_if.sv =====
// candidate record channel
interface spobs_cand_if #(
	parameter int POSITION_BITS  = 31,
	parameter int RECORD_ID_BITS = 16
);
	logic                              valid;
	logic                              ready;
	logic                              flush;
	logic [RECORD_ID_BITS-1:0]         record_id;
	logic [POSITION_BITS-1:0]          interval_start;
	logic [POSITION_BITS-1:0]          interval_end;
	logic [spobs_pkg::STEM_ONE_W-1:0]   stem_one_pair;
	logic [spobs_pkg::STEM_TWO_W-1:0]   stem_two_pair;
	logic [spobs_pkg::STEM_THREE_W-1:0] stem_three_pair;
	logic [spobs_pkg::STEM_FOUR_W-1:0]  stem_four_pair;
	logic [spobs_pkg::INTRON_W-1:0]     intron_length;

	modport source (
		output valid, flush, record_id, interval_start, interval_end,
			stem_one_pair, stem_two_pair, stem_three_pair, stem_four_pair, intron_length,
		input  ready
	);
	modport sink (
		input  valid, flush, record_id, interval_start, interval_end,
			stem_one_pair, stem_two_pair, stem_three_pair, stem_four_pair, intron_length,
		output ready
	);
endinterface

// ===== hdl/spobs_best_if.sv =====
// best record channel
interface spobs_best_if #(
	parameter int POSITION_BITS  = 31,
	parameter int RECORD_ID_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic [RECORD_ID_BITS-1:0]    best_id;
	logic [spobs_pkg::SCORE_W-1:0] best_score;
	logic [POSITION_BITS-1:0]     best_start;
	logic [POSITION_BITS-1:0]     best_end;

	modport source (
		output valid, best_id, best_score, best_start, best_end,
		input  ready
	);
	modport sink (
		input  valid, best_id, best_score, best_start, best_end,
		output ready
	);
endinterface

// ===== hdl/spobs_score.sv =====
// mismatch score of one candidate: four stem sums plus intron penalty
module spobs_score (
	input  logic [spobs_pkg::STEM_ONE_W-1:0]   stem_one_pair,
	input  logic [spobs_pkg::STEM_TWO_W-1:0]   stem_two_pair,
	input  logic [spobs_pkg::STEM_THREE_W-1:0] stem_three_pair,
	input  logic [spobs_pkg::STEM_FOUR_W-1:0]  stem_four_pair,
	input  spobs_pkg::intron_t                 intron_length,
	output spobs_pkg::score_t                  score
);

	spobs_pkg::score_t one_sum, two_sum, three_sum, four_sum, penalty;

	// per-stem sums, evaluated side by side
	always_comb begin
		one_sum   = spobs_pkg::stem_cost(stem_one_pair, spobs_pkg::STEM_ONE_N);
		two_sum   = spobs_pkg::stem_cost(spobs_pkg::stem_word_t'(stem_two_pair),
			spobs_pkg::STEM_TWO_N);
		three_sum = spobs_pkg::stem_cost(spobs_pkg::stem_word_t'(stem_three_pair),
			spobs_pkg::STEM_THREE_N);
		four_sum  = spobs_pkg::stem_cost(spobs_pkg::stem_word_t'(stem_four_pair),
			spobs_pkg::STEM_FOUR_N);
	end

	// long intron penalty
	assign penalty = (intron_length > spobs_pkg::INTRON_LIMIT) ?
		spobs_pkg::INTRON_PENALTY : '0;

	// final tree, at most 102 so no overflow
	assign score = (one_sum + two_sum) + (three_sum + four_sum) + penalty;

endmodule

// ===== hdl/spobs_select.sv =====
// cluster tracker: holds the best record and decides replace or close
module spobs_select #(
	parameter int POSITION_BITS  = 31,
	parameter int RECORD_ID_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spobs_pkg::sel_ctrl_t      ctrl,
	input  logic                      advance,
	input  logic [RECORD_ID_BITS-1:0] record_id,
	input  logic [POSITION_BITS-1:0]  interval_start,
	input  logic [POSITION_BITS-1:0]  interval_end,
	input  spobs_pkg::score_t         score,
	output logic                      emit,
	output logic [RECORD_ID_BITS-1:0] held_id,
	output spobs_pkg::score_t         held_score,
	output logic [POSITION_BITS-1:0]  held_start,
	output logic [POSITION_BITS-1:0]  held_end
);

	logic                      holding_q;
	logic [RECORD_ID_BITS-1:0] held_id_q;
	spobs_pkg::score_t         held_score_q;
	logic [POSITION_BITS-1:0]  held_start_q;
	logic [POSITION_BITS-1:0]  held_end_q;
	logic                      disjoint;
	logic                      load;

	// overlap test against the held interval
	assign disjoint = (interval_start > held_end_q) || (interval_end < held_start_q);

	// close the cluster on flush or on a disjoint record
	assign emit = ctrl.valid && holding_q && (ctrl.flush || disjoint);

	// new cluster, or strictly better record within the cluster
	assign load = !ctrl.flush && (!holding_q || disjoint || (score < held_score_q));

	// holding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
		end else if (advance) begin
			holding_q <= !ctrl.flush;
		end
	end

	// held record
	always_ff @(posedge clk) begin
		if (advance && load) begin
			held_id_q    <= record_id;
			held_score_q <= score;
			held_start_q <= interval_start;
			held_end_q   <= interval_end;
		end
	end

	assign held_id    = held_id_q;
	assign held_score = held_score_q;
	assign held_start = held_start_q;
	assign held_end   = held_end_q;

endmodule

// ===== hdl/stem_pairing_overlap_best_select_core.sv =====
// top level: input register, scoring, cluster select and result register
//
//  channel | dir | handshake     | payload
//  cand    | in  | valid/ready   | flush, record_id, interval, four stems, intron_length
//  best    | out | valid/ready   | best_id, best_score, best_start, best_end
//
// one request per cycle unless a closing request stalls on a full result register
// the cycle path is the score adder tree feeding the held-score compare
// reset clears the input stage, the holding flag and the result register valid
// when the result register is full and not taken, only a request that closes a
// cluster waits; others still pass and may update the held record
module stem_pairing_overlap_best_select_core #(
	parameter int POSITION_BITS  = 31,
	parameter int RECORD_ID_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	spobs_cand_if.sink   cand,
	spobs_best_if.source best
);

	logic                                 valid_s1;
	logic                                 flush_s1;
	logic [RECORD_ID_BITS-1:0]            id_s1;
	logic [POSITION_BITS-1:0]             start_s1;
	logic [POSITION_BITS-1:0]             end_s1;
	logic [spobs_pkg::STEM_ONE_W-1:0]     stem_one_s1;
	logic [spobs_pkg::STEM_TWO_W-1:0]     stem_two_s1;
	logic [spobs_pkg::STEM_THREE_W-1:0]   stem_three_s1;
	logic [spobs_pkg::STEM_FOUR_W-1:0]    stem_four_s1;
	spobs_pkg::intron_t                   intron_s1;

	spobs_pkg::score_t         score;
	spobs_pkg::sel_ctrl_t      ctrl;
	logic                      emit;
	logic                      advance;
	logic                      accept;
	logic [RECORD_ID_BITS-1:0] held_id;
	spobs_pkg::score_t         held_score;
	logic [POSITION_BITS-1:0]  held_start;
	logic [POSITION_BITS-1:0]  held_end;

	logic                      out_valid_q;
	logic [RECORD_ID_BITS-1:0] out_id_q;
	spobs_pkg::score_t         out_score_q;
	logic [POSITION_BITS-1:0]  out_start_q;
	logic [POSITION_BITS-1:0]  out_end_q;

	// stage 1 moves on unless it must emit into a full result register that is not taken
	assign advance    = valid_s1 && (!emit || !out_valid_q || best.ready);
	assign cand.ready = !valid_s1 || advance;
	assign accept     = cand.valid && cand.ready;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1      <= cand.flush;
			id_s1         <= cand.record_id;
			start_s1      <= cand.interval_start;
			end_s1        <= cand.interval_end;
			stem_one_s1   <= cand.stem_one_pair;
			stem_two_s1   <= cand.stem_two_pair;
			stem_three_s1 <= cand.stem_three_pair;
			stem_four_s1  <= cand.stem_four_pair;
			intron_s1     <= cand.intron_length;
		end
	end

	// scoring
	spobs_score u_score (
		.stem_one_pair   (stem_one_s1),
		.stem_two_pair   (stem_two_s1),
		.stem_three_pair (stem_three_s1),
		.stem_four_pair  (stem_four_s1),
		.intron_length   (intron_s1),
		.score           (score)
	);

	// cluster select
	assign ctrl.valid = valid_s1;
	assign ctrl.flush = flush_s1;

	spobs_select #(
		.POSITION_BITS  (POSITION_BITS),
		.RECORD_ID_BITS (RECORD_ID_BITS)
	) u_select (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.advance        (advance),
		.record_id      (id_s1),
		.interval_start (start_s1),
		.interval_end   (end_s1),
		.score          (score),
		.emit           (emit),
		.held_id        (held_id),
		.held_score     (held_score),
		.held_start     (held_start),
		.held_end       (held_end)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (best.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_id_q    <= held_id;
			out_score_q <= held_score;
			out_start_q <= held_start;
			out_end_q   <= held_end;
		end
	end

	assign best.valid      = out_valid_q;
	assign best.best_id    = out_id_q;
	assign best.best_score = out_score_q;
	assign best.best_start = out_start_q;
	assign best.best_end   = out_end_q;

endmodule
